FILE: rtl/core/kae_pkg.sv
package kae_pkg;

	localparam int unsigned QW  = 32;
	localparam int unsigned TSW = 16;
	localparam int unsigned IW  = 3;

	localparam logic [TSW-1:0] TS_RESET = 16'd655;

	localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

	typedef enum logic [IW-1:0] {
		REG_TIME_STEP = 3'd0,
		REG_GAIN_AA   = 3'd1,
		REG_GAIN_AC   = 3'd2,
		REG_GAIN_VA   = 3'd3,
		REG_GAIN_VC   = 3'd4,
		REG_GAIN_CA   = 3'd5,
		REG_GAIN_CC   = 3'd6
	} kae_reg_t;

	typedef enum logic [0:0] {
		REQ_SEED = 1'b0,
		REQ_MEAS = 1'b1
	} kae_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_VDT,
		ST_AHD,
		ST_ADT,
		ST_VPR,
		ST_IA,
		ST_K0,
		ST_K1,
		ST_K2,
		ST_K3,
		ST_K4,
		ST_K5,
		ST_SUM,
		ST_ACC,
		ST_FIN
	} kae_state_t;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_TS_TS,
		MUL_VEL_DT,
		MUL_ACC_HDT2,
		MUL_ACC_DT,
		MUL_G0_IA,
		MUL_G1_IC,
		MUL_G2_IA,
		MUL_G3_IC,
		MUL_G4_IA,
		MUL_G5_IC
	} kae_mul_t;

	typedef enum logic [3:0] {
		ALU_NONE,
		ALU_HDT2,
		ALU_ALT_VEL,
		ALU_ALT_ACC,
		ALU_VEL_PRED,
		ALU_INNOV_ALT,
		ALU_INNOV_ACC,
		ALU_SUM_LOAD,
		ALU_SUM_ADD,
		ALU_ALT_UPD,
		ALU_VEL_UPD,
		ALU_ACC_UPD
	} kae_alu_t;

	typedef struct packed {
		kae_mul_t mul_op;
		kae_alu_t alu_op;
		logic     capture;
		logic     seed;
		logic     publish;
	} kae_cmd_t;

	// saturate a 33-bit two's complement sum to Q16.16
	function automatic logic signed [QW-1:0] kae_sat(input logic [QW:0] v);
		if (v[QW] != v[QW-1]) begin
			return v[QW] ? Q_MIN : Q_MAX;
		end
		return v[QW-1:0];
	endfunction

	// Q16.16 product: round half up, then saturate
	function automatic logic signed [QW-1:0] kae_qround(input logic signed [2*QW-1:0] p);
		logic signed [2*QW-1:0] r;
		r = (p + 64'sd32768) >>> 16;
		if ((&r[2*QW-1:QW-1]) || !(|r[2*QW-1:QW-1])) begin
			return r[QW-1:0];
		end
		return r[2*QW-1] ? Q_MIN : Q_MAX;
	endfunction

endpackage

FILE: rtl/core/kae_ctrl.sv
module kae_ctrl
	import kae_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     req_type,
	output logic     out_valid,
	input  logic     out_ready,
	output kae_cmd_t cmd
);

	kae_state_t state_q, state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.mul_op  = MUL_NONE;
		cmd.alu_op  = ALU_NONE;
		cmd.capture = 1'b0;
		cmd.seed    = 1'b0;
		cmd.publish = 1'b0;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (req_type == REQ_SEED) begin
						cmd.seed = 1'b1;
						state_d  = ST_FIN;
					end else begin
						state_d = ST_SQ;
					end
				end
			end
			ST_SQ: begin
				cmd.mul_op = MUL_TS_TS;
				state_d    = ST_VDT;
			end
			ST_VDT: begin
				cmd.mul_op = MUL_VEL_DT;
				cmd.alu_op = ALU_HDT2;
				state_d    = ST_AHD;
			end
			ST_AHD: begin
				cmd.mul_op = MUL_ACC_HDT2;
				cmd.alu_op = ALU_ALT_VEL;
				state_d    = ST_ADT;
			end
			ST_ADT: begin
				cmd.mul_op = MUL_ACC_DT;
				cmd.alu_op = ALU_ALT_ACC;
				state_d    = ST_VPR;
			end
			ST_VPR: begin
				cmd.alu_op = ALU_VEL_PRED;
				state_d    = ST_IA;
			end
			ST_IA: begin
				cmd.alu_op = ALU_INNOV_ALT;
				state_d    = ST_K0;
			end
			ST_K0: begin
				cmd.mul_op = MUL_G0_IA;
				cmd.alu_op = ALU_INNOV_ACC;
				state_d    = ST_K1;
			end
			ST_K1: begin
				cmd.mul_op = MUL_G1_IC;
				cmd.alu_op = ALU_SUM_LOAD;
				state_d    = ST_K2;
			end
			ST_K2: begin
				cmd.mul_op = MUL_G2_IA;
				cmd.alu_op = ALU_SUM_ADD;
				state_d    = ST_K3;
			end
			ST_K3: begin
				cmd.mul_op = MUL_G3_IC;
				cmd.alu_op = ALU_ALT_UPD;
				state_d    = ST_K4;
			end
			ST_K4: begin
				cmd.mul_op = MUL_G4_IA;
				cmd.alu_op = ALU_SUM_ADD;
				state_d    = ST_K5;
			end
			ST_K5: begin
				cmd.mul_op = MUL_G5_IC;
				cmd.alu_op = ALU_VEL_UPD;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				cmd.alu_op = ALU_SUM_ADD;
				state_d    = ST_ACC;
			end
			ST_ACC: begin
				cmd.alu_op = ALU_ACC_UPD;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/kae_datapath.sv
module kae_datapath
	import kae_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [IW-1:0]         cfg_index,
	input  logic [QW-1:0]         cfg_data,
	input  kae_cmd_t              cmd,
	input  logic signed [QW-1:0]  meas_altitude,
	input  logic signed [QW-1:0]  seed_velocity,
	input  logic signed [QW-1:0]  meas_acceleration,
	output logic signed [QW-1:0]  est_altitude,
	output logic signed [QW-1:0]  est_velocity,
	output logic signed [QW-1:0]  est_acceleration
);

	logic [TSW-1:0]           ts_q;
	logic signed [QW-1:0]     g0_q, g1_q, g2_q, g3_q, g4_q, g5_q;
	logic signed [QW-1:0]     alt_q, vel_q, acc_q;
	logic signed [QW-1:0]     malt_q, macc_q;
	logic [TSW-1:0]           hdt2_q;
	logic signed [QW-1:0]     ap_q, vp_q, ia_q, ic_q, sum_q;
	logic signed [QW-1:0]     out_alt_q, out_vel_q, out_acc_q;
	logic signed [2*QW-1:0]   prod_s1;

	logic signed [QW-1:0]     op_a, op_b;
	logic signed [2*QW-1:0]   prod_c;
	logic signed [QW-1:0]     mres;
	logic [2*QW-1:0]          hdt2_c;
	logic signed [QW-1:0]     add_x, add_y;
	logic                     add_sub;
	logic signed [QW-1:0]     add_res;
	logic signed [QW-1:0]     dt_w, hdt2_w;

	assign dt_w   = signed'({{(QW-TSW){1'b0}}, ts_q});
	assign hdt2_w = signed'({{(QW-TSW){1'b0}}, hdt2_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= TS_RESET;
			g0_q <= '0;
			g1_q <= '0;
			g2_q <= '0;
			g3_q <= '0;
			g4_q <= '0;
			g5_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIME_STEP: ts_q <= cfg_data[TSW-1:0];
				REG_GAIN_AA:   g0_q <= cfg_data;
				REG_GAIN_AC:   g1_q <= cfg_data;
				REG_GAIN_VA:   g2_q <= cfg_data;
				REG_GAIN_VC:   g3_q <= cfg_data;
				REG_GAIN_CA:   g4_q <= cfg_data;
				REG_GAIN_CC:   g5_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// shared multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.mul_op)
			MUL_TS_TS: begin
				op_a = dt_w;
				op_b = dt_w;
			end
			MUL_VEL_DT: begin
				op_a = vel_q;
				op_b = dt_w;
			end
			MUL_ACC_HDT2: begin
				op_a = acc_q;
				op_b = hdt2_w;
			end
			MUL_ACC_DT: begin
				op_a = acc_q;
				op_b = dt_w;
			end
			MUL_G0_IA: begin
				op_a = g0_q;
				op_b = ia_q;
			end
			MUL_G1_IC: begin
				op_a = g1_q;
				op_b = ic_q;
			end
			MUL_G2_IA: begin
				op_a = g2_q;
				op_b = ia_q;
			end
			MUL_G3_IC: begin
				op_a = g3_q;
				op_b = ic_q;
			end
			MUL_G4_IA: begin
				op_a = g4_q;
				op_b = ia_q;
			end
			MUL_G5_IC: begin
				op_a = g5_q;
				op_b = ic_q;
			end
			default: begin
			end
		endcase
	end

	assign prod_c = 64'(op_a) * 64'(op_b);

	always_ff @(posedge clk) begin
		if (cmd.mul_op != MUL_NONE) begin
			prod_s1 <= prod_c;
		end
	end

	assign mres   = kae_qround(prod_s1);
	assign hdt2_c = prod_s1 + 64'sd65536;

	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		case (cmd.alu_op)
			ALU_ALT_VEL: begin
				add_x = alt_q;
				add_y = mres;
			end
			ALU_ALT_ACC: begin
				add_x = ap_q;
				add_y = mres;
			end
			ALU_VEL_PRED: begin
				add_x = vel_q;
				add_y = mres;
			end
			ALU_INNOV_ALT: begin
				add_x   = malt_q;
				add_y   = ap_q;
				add_sub = 1'b1;
			end
			ALU_INNOV_ACC: begin
				add_x   = macc_q;
				add_y   = acc_q;
				add_sub = 1'b1;
			end
			ALU_SUM_ADD: begin
				add_x = sum_q;
				add_y = mres;
			end
			ALU_ALT_UPD: begin
				add_x = ap_q;
				add_y = sum_q;
			end
			ALU_VEL_UPD: begin
				add_x = vp_q;
				add_y = sum_q;
			end
			ALU_ACC_UPD: begin
				add_x = acc_q;
				add_y = sum_q;
			end
			default: begin
			end
		endcase
	end

	assign add_res = add_sub ? kae_sat({add_x[QW-1], add_x} - {add_y[QW-1], add_y})
	                         : kae_sat({add_x[QW-1], add_x} + {add_y[QW-1], add_y});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_q <= '0;
			vel_q <= '0;
			acc_q <= '0;
		end else if (cmd.seed) begin
			alt_q <= meas_altitude;
			vel_q <= seed_velocity;
			acc_q <= meas_acceleration;
		end else begin
			case (cmd.alu_op)
				ALU_ALT_UPD: alt_q <= add_res;
				ALU_VEL_UPD: vel_q <= add_res;
				ALU_ACC_UPD: acc_q <= add_res;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			malt_q <= meas_altitude;
			macc_q <= meas_acceleration;
		end
		case (cmd.alu_op)
			ALU_HDT2:      hdt2_q <= hdt2_c[TSW+16:17];
			ALU_ALT_VEL:   ap_q   <= add_res;
			ALU_ALT_ACC:   ap_q   <= add_res;
			ALU_VEL_PRED:  vp_q   <= add_res;
			ALU_INNOV_ALT: ia_q   <= add_res;
			ALU_INNOV_ACC: ic_q   <= add_res;
			ALU_SUM_LOAD:  sum_q  <= mres;
			ALU_SUM_ADD:   sum_q  <= add_res;
			ALU_ALT_UPD:   sum_q  <= mres;
			ALU_VEL_UPD:   sum_q  <= mres;
			default: begin
			end
		endcase
		if (cmd.publish) begin
			out_alt_q <= alt_q;
			out_vel_q <= vel_q;
			out_acc_q <= acc_q;
		end
	end

	assign est_altitude     = out_alt_q;
	assign est_velocity     = out_vel_q;
	assign est_acceleration = out_acc_q;

endmodule

FILE: rtl/core/kalman_altitude_estimator.sv
// Altitude/velocity/acceleration estimator with a fixed 3x2 gain.
// Input channel (in_valid/in_ready): one beat is a seed (req_type 0), which
// loads the state and is echoed, or a measurement of altitude and
// acceleration (req_type 1), which runs predict and correct.
// Output channel (out_valid/out_ready): one beat per input beat carrying the
// new state, Q16.16.
// Config port: cfg_we/cfg_index/cfg_data, index 0 is dt, 1..6 the gains;
// write only between items.
// A seed goes from ST_IDLE straight to ST_FIN; a measurement steps through
// ST_SQ to ST_ACC before ST_FIN. One item at a time; the next is taken
// once the current one reaches the output register. A measurement sends
// ten products through the single 32x32 multiplier followed by the
// saturating adder.
// The output register frees the core: a new item is accepted while a result
// waits; a finished item then holds until out_ready empties the register.
// Reset clears the state to zero, dt to 655 and the gains to zero.
module kalman_altitude_estimator
	import kae_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [IW-1:0]        cfg_index,
	input  logic [QW-1:0]        cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 req_type,
	input  logic signed [QW-1:0] meas_altitude,
	input  logic signed [QW-1:0] seed_velocity,
	input  logic signed [QW-1:0] meas_acceleration,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [QW-1:0] est_altitude,
	output logic signed [QW-1:0] est_velocity,
	output logic signed [QW-1:0] est_acceleration
);

	kae_cmd_t cmd;

	kae_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	kae_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.cmd               (cmd),
		.meas_altitude     (meas_altitude),
		.seed_velocity     (seed_velocity),
		.meas_acceleration (meas_acceleration),
		.est_altitude      (est_altitude),
		.est_velocity      (est_velocity),
		.est_acceleration  (est_acceleration)
	);

endmodule

FILE: rtl/core/kae_checker.sv
module kae_checker
	import kae_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 req_type,
	input logic signed [QW-1:0] meas_altitude,
	input logic signed [QW-1:0] seed_velocity,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic signed [QW-1:0] est_altitude,
	input logic signed [QW-1:0] est_velocity,
	input logic signed [QW-1:0] est_acceleration
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(est_altitude) && $stable(est_velocity)
			&& $stable(est_acceleration))
		else $error("output beat changed while stalled");

	// one item in flight: no back-to-back accepts
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while busy");

	// a seed into an empty output is echoed as the new altitude and velocity
	a_seed_echo: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_SEED) && !out_valid |=> ##1
			(out_valid && est_altitude == $past(meas_altitude, 2)
			&& est_velocity == $past(seed_velocity, 2)))
		else $error("seed not echoed");

endmodule

bind kalman_altitude_estimator kae_checker u_kae_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.req_type      (req_type),
	.meas_altitude (meas_altitude),
	.seed_velocity (seed_velocity),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.est_altitude  (est_altitude),
	.est_velocity  (est_velocity),
	.est_acceleration (est_acceleration)
);
